// ===== src/hbe_pkg.sv =====
// Shared constants, request codes and the command type for the Huffman byte encoder.
// No dependencies; compile first.
package hbe_pkg;

    localparam int FUNC_W      = 2;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_WORD_W = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int BYTE_W      = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    localparam logic [SYMBOL_W-1:0] CR_BYTE = 8'd13;

    localparam logic DROP_CR_RESET = 1'b1;

    localparam int DEF_SYMBOL_COUNT = 256;
    localparam int DEF_MAX_CODE_LEN = 32;

    localparam int QUEUE_DEPTH = 4;

    // One unit of work for the packer: append a code or flush the tail bits.
    typedef struct packed {
        logic                   is_flush;
        logic [CODE_WORD_W-1:0] word;
        logic [CODE_LEN_W-1:0]  len;
    } cmd_t;

endpackage

// ===== src/hbe_ifs.sv =====
// Channel interfaces for the Huffman byte encoder: request, result and configuration.
// Depends on hbe_pkg.
interface hbe_req_if
    import hbe_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_WORD_W-1:0] code_word;
    logic [CODE_LEN_W-1:0]  code_len;

    modport source (output valid, func, symbol, code_word, code_len, input ready);
    modport sink   (input valid, func, symbol, code_word, code_len, output ready);
endinterface

interface hbe_rsp_if
    import hbe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;

    modport source (output valid, packed_byte, last_of_run, input ready);
    modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

interface hbe_cfg_if
    import hbe_pkg::*;
();
    logic valid;
    logic ready;
    logic drop_cr;

    modport source (output valid, drop_cr, input ready);
    modport sink   (input valid, drop_cr, output ready);
endinterface

// ===== src/hbe_front.sv =====
// Front end: accepts requests, owns the code table and the drop_cr register,
// and turns encode and flush requests into packer commands. Depends on hbe_pkg, hbe_ifs.
module hbe_front
    import hbe_pkg::*;
#(
    parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    hbe_req_if.sink     req,
    hbe_cfg_if.sink     cfg,
    output logic        push_valid,
    output cmd_t        push_cmd,
    input  logic        push_ready
);

    localparam int IDX_W     = $clog2(SYMBOL_COUNT);
    localparam int SYM_EXT_W = SYMBOL_W + 1;
    localparam int LEN_EXT_W = CODE_LEN_W + 1;
    localparam int ENTRY_W   = CODE_LEN_W + CODE_WORD_W;

    logic [ENTRY_W-1:0]     table_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] entry_vld_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_vld_reg;
    logic                   s1_valid_reg;
    logic                   s1_flush_reg;
    logic                   drop_cr_reg;

    logic                   accept;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [CODE_LEN_W-1:0]  len_sat;
    logic [CODE_WORD_W-1:0] word_masked;
    logic                   load_we;
    logic                   enc_take;
    logic                   flush_take;
    logic                   advance;
    logic                   discard;
    logic [CODE_LEN_W-1:0]  s1_len;

    assign accept   = req.valid && req.ready;
    assign in_range = {1'b0, req.symbol} < SYM_EXT_W'(SYMBOL_COUNT);
    assign idx      = req.symbol[IDX_W-1:0];
    assign len_sat  = (req.code_len > CODE_LEN_W'(MAX_CODE_LEN)) ?
                      CODE_LEN_W'(MAX_CODE_LEN) : req.code_len;

    // Keep only the low len_sat bits of the code word.
    always_comb
    begin
        for (int i = 0; i < CODE_WORD_W; i++)
        begin
            word_masked[i] = req.code_word[i] && ({1'b0, len_sat} > LEN_EXT_W'(i));
        end
    end

    assign load_we    = accept && (req.func == FUNC_LOAD) && in_range;
    assign enc_take   = accept && (req.func == FUNC_ENCODE) && in_range &&
                        !(drop_cr_reg && (req.symbol == CR_BYTE));
    assign flush_take = accept && (req.func == FUNC_FLUSH);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            table_mem[idx] <= {len_sat, word_masked};
        end
        if (enc_take)
        begin
            rd_data_reg <= table_mem[idx];
            rd_vld_reg  <= entry_vld_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (load_we)
        begin
            entry_vld_reg[idx] <= 1'b1;
        end
    end

    // Entries never loaded read as zero length.
    assign s1_len  = rd_vld_reg ? rd_data_reg[ENTRY_W-1:CODE_WORD_W] : '0;
    assign discard = s1_valid_reg && !s1_flush_reg && (s1_len == '0);
    assign advance = !s1_valid_reg || discard || push_ready;

    assign req.ready  = advance;
    assign push_valid = s1_valid_reg && !discard;
    assign push_cmd   = '{is_flush: s1_flush_reg,
                          word:     rd_data_reg[CODE_WORD_W-1:0],
                          len:      s1_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= enc_take || flush_take;
            s1_flush_reg <= flush_take;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_cr_reg <= DROP_CR_RESET;
        end
        else if (cfg.valid)
        begin
            drop_cr_reg <= cfg.drop_cr;
        end
    end

endmodule

// ===== src/hbe_queue.sv =====
// Command queue between front end and packer.
// Depends on hbe_pkg.
module hbe_queue
    import hbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/hbe_back.sv =====
// Back end: bit accumulator that appends codes and sends one packed byte per cycle
// while rsp is ready, through a registered output. Depends on hbe_pkg, hbe_ifs.
module hbe_back
    import hbe_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    input  cmd_t    pop_cmd,
    output logic    pop_ready,
    hbe_rsp_if.source rsp
);

    localparam int ACC_W = MAX_CODE_LEN + 7;
    localparam int TOT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  acc_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              can_emit;
    logic              have_byte;
    logic              emit_now;
    logic [TOT_W-1:0]  rem_total;
    logic              rem_small;
    logic [2:0]        rem3;
    logic [6:0]        pend_mask;
    logic [6:0]        pend;
    logic              flush_out;
    logic              pop_enc;
    logic              pop_flush;
    logic [ACC_W-1:0]  acc_merge;
    logic [TOT_W-1:0]  total_merge;
    logic [BYTE_W-1:0] emit_byte;
    logic [BYTE_W-1:0] flush_byte;

    assign can_emit  = !out_valid_reg || rsp.ready;
    assign have_byte = (total_reg >= TOT_W'(8));
    assign emit_now  = have_byte && can_emit;
    assign rem_total = emit_now ? (total_reg - TOT_W'(8)) : total_reg;
    assign rem_small = (rem_total < TOT_W'(8));
    assign rem3      = rem_total[2:0];
    assign pend_mask = 7'((8'd1 << rem3) - 8'd1);
    assign pend      = acc_reg[6:0] & pend_mask;

    // A flush with tail bits needs the output slot to itself.
    assign flush_out = (rem_total != '0) && !emit_now && can_emit;
    assign pop_ready = pop_valid && rem_small &&
                       (!pop_cmd.is_flush || (rem_total == '0) || flush_out);
    assign pop_enc   = pop_ready && !pop_cmd.is_flush;
    assign pop_flush = pop_ready && pop_cmd.is_flush;

    assign acc_merge   = (ACC_W'(pend) << pop_cmd.len) | ACC_W'(pop_cmd.word);
    assign total_merge = rem_total + TOT_W'(pop_cmd.len);
    assign emit_byte   = BYTE_W'(acc_reg >> (total_reg - TOT_W'(8)));
    assign flush_byte  = BYTE_W'({1'b0, pend} << (4'd8 - {1'b0, rem3}));

    always_ff @(posedge clk)
    begin
        if (pop_enc)
        begin
            acc_reg <= acc_merge;
        end
        if (emit_now)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= (total_reg - TOT_W'(8)) < TOT_W'(8);
        end
        else if (pop_flush && (rem_total != '0))
        begin
            out_byte_reg <= flush_byte;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_enc)
            begin
                total_reg <= total_merge;
            end
            else if (pop_flush)
            begin
                total_reg <= '0;
            end
            else
            begin
                total_reg <= rem_total;
            end

            if (emit_now || (pop_flush && (rem_total != '0)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.packed_byte = out_byte_reg;
    assign rsp.last_of_run = out_last_reg;

endmodule

// ===== src/huffman_byte_encoder_packer_core.sv =====
// Top level of the Huffman byte encoder and bit packer.
// Depends on hbe_pkg, hbe_ifs, hbe_front, hbe_queue, hbe_back.
//
// Usage:
//   req  - request channel: func selects load (write one table entry), encode
//          (append the code of symbol) or flush (pad the tail bits with zeros).
//   rsp  - result channel: one packed byte per transfer, earliest code bit in
//          the MSB; last_of_run marks the final byte caused by one request.
//   cfg  - write channel for drop_cr; always ready, write it while idle.
// Timing:
//   A request is taken every cycle while the command queue has room. An encode
//   passes the front-stage register, the queue and the accumulator to the output
//   register; a flush's tail byte goes from the queue to it. The packer sends one
//   byte per cycle while rsp is ready. An encode merges in the same cycle as the
//   previous one's last byte; a flush with tail bits waits for the output to itself.
//   Loads and skipped encodes never reach the packer.
// Reset:
//   Clears all table entries to zero length, the pending bits and the queue,
//   and sets drop_cr. No clearing pass; requests are taken right away.
// Stall:
//   When rsp is stalled the output register holds its byte, the packer stops,
//   the queue fills and req.ready drops once the front stage cannot advance.
module huffman_byte_encoder_packer_core
    import hbe_pkg::*;
#(
    parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  logic      clk,
    input  logic      rst_n,
    hbe_req_if.sink   req,
    hbe_rsp_if.source rsp,
    hbe_cfg_if.sink   cfg
);

    // Front to queue.
    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;

    // Queue to packer.
    logic pop_valid;
    cmd_t pop_cmd;
    logic pop_ready;

    // Classify requests, look up codes, pass on only flushes and encodes with a code.
    hbe_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Decouple the lookup from the byte-serial packer.
    hbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Append codes, send full bytes and pad the tail bits on a flush.
    hbe_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule

// ===== src/hbe_checker.sv =====
// Port-level checks for the Huffman byte encoder, bound to the top level.
// Depends on hbe_pkg and huffman_byte_encoder_packer_core.
module hbe_checker
    import hbe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [FUNC_W-1:0] req_func,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [BYTE_W-1:0] rsp_byte,
    input logic              rsp_last
);

    // Count requests that may still end a run; saturate and stop tracking at max.
    logic [7:0] open_cnt_reg;
    logic       req_opens;
    logic       rsp_closes;

    assign req_opens  = req_valid && req_ready &&
                        ((req_func == FUNC_ENCODE) || (req_func == FUNC_FLUSH));
    assign rsp_closes = rsp_valid && rsp_ready && rsp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_cnt_reg <= '0;
        end
        else if (open_cnt_reg != 8'hFF)
        begin
            if (req_opens && !rsp_closes)
            begin
                open_cnt_reg <= open_cnt_reg + 1'b1;
            end
            else if (rsp_closes && !req_opens && (open_cnt_reg != '0))
            begin
                open_cnt_reg <= open_cnt_reg - 1'b1;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && req_ready))
        else $error("request ready dropped without a request taken");

    a_last_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_closes |-> (open_cnt_reg != '0))
        else $error("end of run without an encode or flush request");

endmodule

bind huffman_byte_encoder_packer_core hbe_checker u_hbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_byte  (rsp.packed_byte),
    .rsp_last  (rsp.last_of_run)
);

// ===== tb/huffman_byte_encoder_packer_core_test.sv =====
// Self-checking testbench for huffman_byte_encoder_packer_core: table loads, encodes, flushes.
// Depends on hbe_pkg, hbe_ifs and huffman_byte_encoder_packer_core from src; drives the request
// and drop_cr channels, checks every packed byte against a cycle-free table and bit accumulator model.
module huffman_byte_encoder_packer_core_test
    import hbe_pkg::*;
;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int MAX_LEN        = DEF_MAX_CODE_LEN;
    localparam int PREDICTED      = -1;    // row takes its bytes from the model
    localparam int DRAIN_CYCLES   = 8;     // lets the encode path settle, plus margin
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int DIRECTED_ROWS  = 23;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [SYMBOL_W-1:0]    symbol;
        logic [CODE_WORD_W-1:0] code_word;
        logic [CODE_LEN_W-1:0]  code_len;
    } request_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
    } byte_out_t;

    // One directed row: the request, plus a typed-in result where it is obvious.
    // fixed_count bytes of fixed_byte are expected, the last one marked last_of_run.
    typedef struct packed {
        request_t          req;
        int                fixed_count;
        logic [BYTE_W-1:0] fixed_byte;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hbe_req_if req_ch ();
    hbe_rsp_if rsp_ch ();
    hbe_cfg_if cfg_ch ();

    huffman_byte_encoder_packer_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Encoder model state: code table, pending tail bits and the drop_cr register.
    logic [CODE_WORD_W-1:0] code_words [256];
    logic [CODE_LEN_W-1:0]  code_lens  [256];
    logic [6:0]             pend_bits;
    logic [2:0]             pend_count;
    logic                   drop_cr_model;

    // Bytes produced by the most recent modeled request.
    logic [BYTE_W-1:0] pred_byte [4];
    logic              pred_last [4];

    byte_out_t expected_bytes [$];

    int sent_count   = 0;
    int load_count   = 0;
    int encode_count = 0;
    int flush_count  = 0;
    int bytes_taken  = 0;
    int mismatches   = 0;
    int cfg_writes   = 0;

    // Directed script, run right after reset with drop_cr at its reset value of 1.
    directed_row_t script [DIRECTED_ROWS] = '{
        // empty table after reset: encode emits nothing
        '{'{FUNC_ENCODE, 8'd65,  32'h0000_0000, 6'd0},  0, 8'h00},
        // flush with nothing pending
        '{'{FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  0, 8'h00},
        // unused function code with every field bit set
        '{'{FUNC_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63}, 0, 8'h00},
        '{'{FUNC_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd8},  0, 8'h00},
        '{'{FUNC_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1, 8'hFF},
        // longest code, all ones
        '{'{FUNC_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32}, 0, 8'h00},
        '{'{FUNC_ENCODE, 8'd255, 32'h0000_0000, 6'd0},  4, 8'hFF},
        // overlong length saturates to the maximum
        '{'{FUNC_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd63}, 0, 8'h00},
        '{'{FUNC_ENCODE, 8'd1,   32'h0000_0000, 6'd0},  4, 8'hFF},
        // code bits above the length are ignored
        '{'{FUNC_LOAD,   8'd2,   32'hFFFF_FFFE, 6'd1},  0, 8'h00},
        '{'{FUNC_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  0, 8'h00},
        '{'{FUNC_LOAD,   8'd3,   32'h0000_0001, 6'd1},  0, 8'h00},
        '{'{FUNC_ENCODE, 8'd3,   32'h0000_0000, 6'd0},  0, 8'h00},
        // two pending bits "01" padded with zeros
        '{'{FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1, 8'h40},
        // carriage return is dropped while drop_cr is set
        '{'{FUNC_LOAD,   CR_BYTE, 32'h0000_0005, 6'd3}, 0, 8'h00},
        '{'{FUNC_ENCODE, CR_BYTE, 32'h0000_0000, 6'd0}, 0, 8'h00},
        '{'{FUNC_LOAD,   8'd4,   32'h0000_007F, 6'd7},  0, 8'h00},
        '{'{FUNC_ENCODE, 8'd4,   32'h0000_0000, 6'd0},  PREDICTED, 8'h00},
        // seven pending bits plus a 32-bit code: the most bytes one request yields
        '{'{FUNC_ENCODE, 8'd255, 32'h0000_0000, 6'd0},  PREDICTED, 8'h00},
        '{'{FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  PREDICTED, 8'h00},
        // zero length load clears the code
        '{'{FUNC_LOAD,   8'd5,   32'h0000_ABCD, 6'd0},  0, 8'h00},
        '{'{FUNC_ENCODE, 8'd5,   32'h0000_0000, 6'd0},  0, 8'h00},
        '{'{FUNC_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  0, 8'h00}
    };

    // Apply one request to the model; fill pred_byte/pred_last and return the count.
    task automatic predict_request(input request_t r, output int n);
        logic [63:0]           acc;
        logic [CODE_LEN_W-1:0] clen;
        int                    total;
        n = 0;
        case (r.func)
            FUNC_LOAD:
            begin
                clen = (r.code_len > CODE_LEN_W'(MAX_LEN)) ? CODE_LEN_W'(MAX_LEN) : r.code_len;
                code_lens[r.symbol]  = clen;
                code_words[r.symbol] = CODE_WORD_W'({32'b0, r.code_word} & ((64'd1 << clen) - 64'd1));
            end
            FUNC_ENCODE:
            begin
                if (!(drop_cr_model && r.symbol == CR_BYTE) && code_lens[r.symbol] != 0)
                begin
                    clen  = code_lens[r.symbol];
                    acc   = ({57'b0, pend_bits} << clen) | {32'b0, code_words[r.symbol]};
                    total = pend_count + clen;
                    // peel off whole bytes, earliest bits first
                    while (total >= 8)
                    begin
                        total = total - 8;
                        pred_byte[n] = BYTE_W'(acc >> total);
                        pred_last[n] = 1'b0;
                        n++;
                    end
                    if (n > 0)
                        pred_last[n-1] = 1'b1;
                    pend_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                    pend_count = 3'(total);
                end
            end
            FUNC_FLUSH:
            begin
                if (pend_count != 0)
                begin
                    pred_byte[0] = BYTE_W'({1'b0, pend_bits} << (8 - pend_count));
                    pred_last[0] = 1'b1;
                    n = 1;
                    pend_bits  = '0;
                    pend_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Present one request after a random gap, hold it until accepted, then queue
    // the bytes it must produce (typed-in ones where the row gives them).
    task automatic send_request(input request_t r, input int fixed_count,
                                input logic [BYTE_W-1:0] fixed_byte);
        int gap;
        int n;
        gap = (sent_count % 50 < 10) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= r.func;
        req_ch.symbol    <= r.symbol;
        req_ch.code_word <= r.code_word;
        req_ch.code_len  <= r.code_len;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
        case (r.func)
            FUNC_LOAD:   load_count++;
            FUNC_ENCODE: encode_count++;
            FUNC_FLUSH:  flush_count++;
            default: ;
        endcase
        predict_request(r, n);
        if (fixed_count != PREDICTED)
        begin
            for (int i = 0; i < fixed_count; i++)
                expected_bytes.push_back('{fixed_byte, i == fixed_count - 1});
        end
        else
        begin
            for (int i = 0; i < n; i++)
                expected_bytes.push_back('{pred_byte[i], pred_last[i]});
        end
    endtask

    // Drop valid, wait for every queued byte, then let skipped requests settle.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write drop_cr while the block is idle.
    task automatic write_drop_cr(input logic value);
        drain_results();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.drop_cr <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid  <= 1'b0;
        drop_cr_model = value;
        cfg_writes++;
    endtask

    // Mostly small symbols so that encodes hit loaded entries; carriage return often.
    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return CR_BYTE;
        else if (pick < 20)
            return SYMBOL_W'($urandom_range(0, 255));
        else
            return SYMBOL_W'($urandom_range(0, 15));
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       len_pick;
        pick        = $urandom_range(0, 99);
        r.symbol    = pick_symbol();
        r.code_word = $urandom;
        r.code_len  = '0;
        if (pick < 22)
        begin
            r.func   = FUNC_LOAD;
            len_pick = $urandom_range(0, 19);
            if (len_pick == 0)
                r.code_len = '0;
            else if (len_pick == 1)
                r.code_len = CODE_LEN_W'($urandom_range(MAX_LEN + 1, 63));
            else if (len_pick == 2)
                r.code_len = CODE_LEN_W'(MAX_LEN);
            else
                r.code_len = CODE_LEN_W'($urandom_range(1, 12));
        end
        else if (pick < 82)
        begin
            // encode ignores the code fields; keep them random anyway
            r.func     = FUNC_ENCODE;
            r.code_len = CODE_LEN_W'($urandom_range(0, 63));
        end
        else if (pick < 96)
        begin
            r.func = FUNC_FLUSH;
        end
        else
        begin
            r.func     = FUNC_UNUSED;
            r.symbol   = SYMBOL_W'($urandom_range(0, 255));
            r.code_len = CODE_LEN_W'($urandom_range(0, 63));
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_request(), PREDICTED, '0);
    endtask

    // Compare one accepted byte with the oldest expectation.
    task automatic check_byte(input logic [BYTE_W-1:0] got_byte, input logic got_last);
        byte_out_t want;
        bytes_taken++;
        if (expected_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] unexpected byte %02h last=%0b", $time, got_byte, got_last);
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (want.packed_byte !== got_byte || want.last_of_run !== got_last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] byte %0d: expected %02h last=%0b, got %02h last=%0b",
                             $time, bytes_taken, want.packed_byte, want.last_of_run,
                             got_byte, got_last);
            end
        end
    endtask

    // Result side: stall at random between bytes, with stretches of none.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (bytes_taken % 40 < 8) ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            check_byte(rsp_ch.packed_byte, rsp_ch.last_of_run);
        end
    end

    // Main sequence: reset, directed script, then random phases with drop_cr
    // cleared, set and cleared again.
    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FUNC_LOAD;
        req_ch.symbol    <= '0;
        req_ch.code_word <= '0;
        req_ch.code_len  <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.drop_cr   <= DROP_CR_RESET;

        for (int i = 0; i < 256; i++)
        begin
            code_words[i] = '0;
            code_lens[i]  = '0;
        end
        pend_bits     = '0;
        pend_count    = '0;
        drop_cr_model = DROP_CR_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(script[i].req, script[i].fixed_count, script[i].fixed_byte);

        write_drop_cr(1'b0);
        run_random(RANDOM_PER_PHASE);
        write_drop_cr(1'b1);
        run_random(RANDOM_PER_PHASE);
        write_drop_cr(1'b0);
        run_random(RANDOM_PER_PHASE);

        drain_results();

        $display("Covered %0d requests: %0d loads, %0d encodes, %0d flushes; %0d drop_cr writes.",
                 sent_count, load_count, encode_count, flush_count, cfg_writes);
        $display("Checked %0d packed bytes, %0d mismatches, %0d still outstanding.",
                 bytes_taken, mismatches, expected_bytes.size());
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timeout with %0d bytes outstanding.", expected_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== huffman_byte_encoder_packer_core.f =====
src/hbe_pkg.sv
src/hbe_ifs.sv
src/hbe_front.sv
src/hbe_queue.sv
src/hbe_back.sv
src/huffman_byte_encoder_packer_core.sv
src/hbe_checker.sv
tb/huffman_byte_encoder_packer_core_test.sv
